FILE: rtl/prrs_pkg.sv
// Shared types and constants of the priority round-robin scheduler.
package prrs_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W        = 16;
    localparam int PRI_W       = 4;
    localparam int IDX_W       = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [PRI_W-1:0] MAIN_PRI_RESET = PRI_W'(9);

    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_YIELD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXIT   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [0:0] REG_MAIN_PRIORITY = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

endpackage

FILE: rtl/priority_round_robin_scheduler.sv
// Top level of the priority round-robin scheduler with its thread table memory.
// Yield reads the running entry and its successor (not with one thread); create and exit shift
// entries one by one. Others fetch the running id; a last exit or empty ring skip the table.
// One request at a time: a new start is taken only while busy is low, a limit set by the
// single read and single write port of the thread table; the receiver never stalls the block.
// Reset: the table holds the main thread, id 0, at main_priority; done pulses once per request.
module priority_round_robin_scheduler
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [prrs_pkg::ADDR_W-1:0]       paddr,
    input  logic [prrs_pkg::DATA_W-1:0]       pwdata,
    output logic [prrs_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [prrs_pkg::FUNC_W-1:0]       func,
    input  logic [prrs_pkg::PRI_W-1:0]        priority_req,
    output logic                              done,
    output logic [prrs_pkg::ID_W-1:0]         running_id,
    output logic [prrs_pkg::ID_W-1:0]         new_id,
    output logic [prrs_pkg::STATUS_W-1:0]     status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_STEP,
        ST_C_PLACE,
        ST_Y_A,
        ST_Y_B,
        ST_E_FIRST,
        ST_E_SHIFT,
        ST_FETCH,
        ST_RESP
    } state_t;

    state_t                               state_reg, state_next;
    logic [prrs_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [prrs_pkg::IDX_W-1:0]           ri_reg, ri_next;
    logic [prrs_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic [prrs_pkg::ID_W-1:0]            idc_reg, idc_next;
    logic [prrs_pkg::PRI_W-1:0]           req_pri_reg, req_pri_next;
    logic [prrs_pkg::PRI_W-1:0]           pri_save_reg, pri_save_next;
    logic                                 to_head_reg, to_head_next;
    logic [prrs_pkg::PRI_W-1:0]           main_pri_reg, main_pri_next;
    logic [prrs_pkg::PRI_W-1:0]           e0_pri_reg, e0_pri_next;
    logic                                 e0_init_reg, e0_init_next;
    logic                                 untouched_reg, untouched_next;
    logic                                 done_reg, done_next;
    logic [prrs_pkg::ID_W-1:0]            running_id_reg, running_id_next;
    logic [prrs_pkg::ID_W-1:0]            new_id_reg, new_id_next;
    logic [prrs_pkg::STATUS_W-1:0]        status_reg, status_next;

    prrs_pkg::entry_t                     entry_mem_reg [prrs_pkg::MAX_THREADS];
    prrs_pkg::entry_t                     rdata_reg;
    logic                                 rd_zero_reg;
    prrs_pkg::entry_t                     rd_view;
    prrs_pkg::entry_t                     mem_wdata;
    logic                                 mem_we;
    logic [prrs_pkg::IDX_W-1:0]           mem_waddr;
    logic [prrs_pkg::IDX_W-1:0]           mem_raddr;

    logic                                 cfg_we;
    logic                                 accept;
    logic [prrs_pkg::CNT_W-1:0]           ri_ext;
    logic [prrs_pkg::CNT_W-1:0]           idx_ext;
    logic [prrs_pkg::CNT_W-1:0]           nxt_ext;
    logic                                 th_now;
    logic                                 th_final;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == prrs_pkg::REG_MAIN_PRIORITY) ?
                    prrs_pkg::DATA_W'(main_pri_reg) : '0;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == prrs_pkg::REG_MAIN_PRIORITY);
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign done       = done_reg;
    assign running_id = running_id_reg;
    assign new_id     = new_id_reg;
    assign status     = status_reg;

    // Entry 0 reads as the main thread until it is first written.
    always_comb
    begin
        if (rd_zero_reg && e0_init_reg)
        begin
            rd_view.id  = '0;
            rd_view.pri = e0_pri_reg;
        end
        else
        begin
            rd_view = rdata_reg;
        end
    end

    assign ri_ext  = prrs_pkg::CNT_W'(ri_reg);
    assign idx_ext = prrs_pkg::CNT_W'(idx_reg);
    assign nxt_ext = ((ri_ext + 1'b1) >= count_reg) ? '0 : (ri_ext + 1'b1);
    assign th_now  = (ri_reg == '0) || (pri_save_reg < rd_view.pri);
    assign th_final = (idx_reg == ri_reg) ? th_now : to_head_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ri_next         = ri_reg;
        idx_next        = idx_reg;
        idc_next        = idc_reg;
        req_pri_next    = req_pri_reg;
        pri_save_next   = pri_save_reg;
        to_head_next    = to_head_reg;
        main_pri_next   = main_pri_reg;
        e0_pri_next     = e0_pri_reg;
        e0_init_next    = e0_init_reg;
        untouched_next  = untouched_reg;
        done_next       = 1'b0;
        running_id_next = running_id_reg;
        new_id_next     = new_id_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_view;
        mem_raddr       = ri_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    main_pri_next = pwdata[prrs_pkg::PRI_W-1:0];
                    if (untouched_reg)
                    begin
                        e0_pri_next = pwdata[prrs_pkg::PRI_W-1:0];
                    end
                end
                if (accept)
                begin
                    untouched_next = 1'b0;
                    new_id_next    = '0;
                    status_next    = prrs_pkg::STATUS_OK;
                    if (count_reg == '0)
                    begin
                        done_next       = 1'b1;
                        running_id_next = '0;
                        status_next     = prrs_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        case (func)
                            prrs_pkg::FUNC_CREATE:
                            begin
                                if (count_reg >= prrs_pkg::CNT_W'(prrs_pkg::MAX_THREADS))
                                begin
                                    status_next = prrs_pkg::STATUS_FULL;
                                    state_next  = ST_FETCH;
                                end
                                else
                                begin
                                    idc_next     = idc_reg + 1'b1;
                                    new_id_next  = idc_reg + 1'b1;
                                    req_pri_next = priority_req;
                                    idx_next     = count_reg[prrs_pkg::IDX_W-1:0];
                                    mem_raddr    = prrs_pkg::IDX_W'(count_reg - 1'b1);
                                    state_next   = ST_C_STEP;
                                end
                            end
                            prrs_pkg::FUNC_YIELD:
                            begin
                                if (count_reg == prrs_pkg::CNT_W'(1))
                                begin
                                    state_next = ST_FETCH;
                                end
                                else
                                begin
                                    mem_raddr  = ri_reg;
                                    state_next = ST_Y_A;
                                end
                            end
                            prrs_pkg::FUNC_EXIT:
                            begin
                                mem_raddr  = ri_reg;
                                state_next = ST_E_FIRST;
                            end
                            default:
                            begin
                                state_next = ST_FETCH;
                            end
                        endcase
                    end
                end
            end
            ST_C_STEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (rd_view.pri > req_pri_reg)
                begin
                    mem_wdata = rd_view;
                    if (idx_reg == prrs_pkg::IDX_W'(1))
                    begin
                        idx_next   = '0;
                        state_next = ST_C_PLACE;
                    end
                    else
                    begin
                        idx_next  = idx_reg - 1'b1;
                        mem_raddr = idx_reg - prrs_pkg::IDX_W'(2);
                    end
                end
                else
                begin
                    mem_wdata.id  = new_id_reg;
                    mem_wdata.pri = req_pri_reg;
                    count_next    = count_reg + 1'b1;
                    if (idx_reg <= ri_reg)
                    begin
                        ri_next = ri_reg + 1'b1;
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_C_PLACE:
            begin
                mem_we        = 1'b1;
                mem_waddr     = '0;
                mem_wdata.id  = new_id_reg;
                mem_wdata.pri = req_pri_reg;
                count_next    = count_reg + 1'b1;
                ri_next       = ri_reg + 1'b1;
                state_next    = ST_FETCH;
            end
            ST_Y_A:
            begin
                pri_save_next = rd_view.pri;
                mem_raddr     = nxt_ext[prrs_pkg::IDX_W-1:0];
                state_next    = ST_Y_B;
            end
            ST_Y_B:
            begin
                if (pri_save_reg < rd_view.pri)
                begin
                    ri_next = '0;
                end
                else
                begin
                    ri_next = nxt_ext[prrs_pkg::IDX_W-1:0];
                end
                state_next = ST_FETCH;
            end
            ST_E_FIRST:
            begin
                pri_save_next = rd_view.pri;
                idx_next      = ri_reg;
                if ((ri_ext + 1'b1) < count_reg)
                begin
                    mem_raddr  = ri_reg + 1'b1;
                    state_next = ST_E_SHIFT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    ri_next    = '0;
                    if (count_reg == prrs_pkg::CNT_W'(1))
                    begin
                        done_next       = 1'b1;
                        running_id_next = '0;
                        status_next     = prrs_pkg::STATUS_EMPTY;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_E_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rd_view;
                if (idx_reg == ri_reg)
                begin
                    to_head_next = th_now;
                end
                if ((idx_ext + prrs_pkg::CNT_W'(2)) < count_reg)
                begin
                    mem_raddr = idx_reg + prrs_pkg::IDX_W'(2);
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (th_final)
                    begin
                        ri_next = '0;
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                mem_raddr  = ri_reg;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                done_next       = 1'b1;
                running_id_next = rd_view.id;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (mem_we && (mem_waddr == '0))
        begin
            e0_init_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= prrs_pkg::CNT_W'(1);
            ri_reg         <= '0;
            idx_reg        <= '0;
            idc_reg        <= '0;
            req_pri_reg    <= '0;
            pri_save_reg   <= '0;
            to_head_reg    <= 1'b0;
            main_pri_reg   <= prrs_pkg::MAIN_PRI_RESET;
            e0_pri_reg     <= prrs_pkg::MAIN_PRI_RESET;
            e0_init_reg    <= 1'b1;
            untouched_reg  <= 1'b1;
            done_reg       <= 1'b0;
            running_id_reg <= '0;
            new_id_reg     <= '0;
            status_reg     <= prrs_pkg::STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ri_reg         <= ri_next;
            idx_reg        <= idx_next;
            idc_reg        <= idc_next;
            req_pri_reg    <= req_pri_next;
            pri_save_reg   <= pri_save_next;
            to_head_reg    <= to_head_next;
            main_pri_reg   <= main_pri_next;
            e0_pri_reg     <= e0_pri_next;
            e0_init_reg    <= e0_init_next;
            untouched_reg  <= untouched_next;
            done_reg       <= done_next;
            running_id_reg <= running_id_next;
            new_id_reg     <= new_id_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem_reg[mem_waddr] <= mem_wdata;
        end
        rdata_reg   <= entry_mem_reg[mem_raddr];
        rd_zero_reg <= (mem_raddr == '0);
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= prrs_pkg::CNT_W'(prrs_pkg::MAX_THREADS))
        else $error("thread count above table size");

    a_ri_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && (count_reg != '0) |-> (ri_ext < count_reg))
        else $error("running index outside the ring");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != prrs_pkg::STATUS_EMPTY) |-> $past(state_reg == ST_RESP))
        else $error("result word without a table read");

    a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == prrs_pkg::STATUS_FULL) |-> (new_id_reg == '0))
        else $error("refused create reported an id");

    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |=> (count_reg == '0))
        else $error("empty ring came back to life");
`endif

endmodule
